[rtl/ccs_pkg.sv]
package ccs_pkg;

  localparam int PADDR_W = 5;

  localparam int SQ1_N = 70;
  localparam int SQ1_M = 35;
  localparam int SQ2_N = 68;
  localparam int SQ2_M = 34;
  localparam int DIV_STEPS = 32;

  // front 5, root 35, setup 5, divide 32, distance 5, root 34, final 1
  localparam int PIPE_DEPTH = 5 + SQ1_M + 5 + DIV_STEPS + 5 + SQ2_M + 1;

  localparam logic [30:0] MIN_LSB   = 31'd7;
  localparam logic [16:0] TAPER_ONE = 17'd65536;
  localparam logic [32:0] QR_LIMIT  = 33'h1_0000_0000;
  localparam logic [32:0] T_ONE     = 33'h1_0000_0000;
  localparam logic [30:0] DIST_MAX  = 31'h7fff_ffff;
  localparam logic [31:0] SD_MIN    = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_COS_YAW     = 3'd2,
    REG_SIN_YAW     = 3'd3,
    REG_TOP_RADIUS  = 3'd4,
    REG_HALF_HEIGHT = 3'd5,
    REG_TAPER_RATIO = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [30:0] r1;
    logic [30:0] r2;
    logic [30:0] h;
    logic [30:0] k2x;
    logic [31:0] k2y;
  } drv_t;

  typedef struct packed {
    logic signed [31:0] sd;
    logic               in_cone;
  } res_t;

endpackage

[rtl/ccs_point_if.sv]
interface ccs_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

[rtl/ccs_result_if.sv]
interface ccs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] signed_distance;
  logic               inside_res;

  modport source (output valid, output signed_distance, output inside_res,
                  input ready);
  modport sink (input valid, input signed_distance, input inside_res,
                output ready);
endinterface

[rtl/capped_cone_sdf.sv]
// Throughput: one request per cycle while the skid entry is empty,
// set by the fully pipelined bit-serial square roots (35 and 34 stages)
// and the 32-stage restoring divider.
// A stalled result is held in an output register plus one skid entry.
// Reset (async, active low) clears all valid bits and loads register defaults;
// derived cone constants settle through a chain of registers after any write.
module capped_cone_sdf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  ccs_point_if.sink                    point_i,
  ccs_result_if.source                 result_o
);
  import ccs_pkg::*;

  // config registers
  logic signed [31:0] off_x_q, off_y_q;
  logic signed [17:0] cos_q, sin_q;
  logic [30:0]        rtop_q, hh_q;
  logic [16:0]        tap_q;
  logic               wr_en;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      cos_q   <= 18'sd65536;
      sin_q   <= '0;
      rtop_q  <= 31'd65536;
      hh_q    <= 31'd65536;
      tap_q   <= 17'd49152;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OFFSET_X:    off_x_q <= pwdata;
        REG_OFFSET_Y:    off_y_q <= pwdata;
        REG_COS_YAW:     cos_q   <= pwdata[17:0];
        REG_SIN_YAW:     sin_q   <= pwdata[17:0];
        REG_TOP_RADIUS:  rtop_q  <= pwdata[30:0];
        REG_HALF_HEIGHT: hh_q    <= pwdata[30:0];
        REG_TAPER_RATIO: tap_q   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OFFSET_X:    prdata = off_x_q;
      REG_OFFSET_Y:    prdata = off_y_q;
      REG_COS_YAW:     prdata = {14'b0, cos_q};
      REG_SIN_YAW:     prdata = {14'b0, sin_q};
      REG_TOP_RADIUS:  prdata = {1'b0, rtop_q};
      REG_HALF_HEIGHT: prdata = {1'b0, hh_q};
      REG_TAPER_RATIO: prdata = {15'b0, tap_q};
      default:         prdata = '0;
    endcase
  end

  // derived cone constants
  logic [30:0] r2a_q, ha_q, r1b_q, r2b_q, hb_q;
  logic [16:0] tpa_q;
  logic [47:0] r1_prod;
  drv_t        drv_q;
  logic [61:0] sqx_q;
  logic [63:0] sqy_q;
  logic [64:0] den_q;

  assign r1_prod = 48'(r2a_q) * 48'(tpa_q);

  always_ff @(posedge clk_i) begin
    r2a_q     <= (rtop_q < MIN_LSB) ? MIN_LSB : rtop_q;
    ha_q      <= (hh_q < MIN_LSB) ? MIN_LSB : hh_q;
    tpa_q     <= (tap_q > TAPER_ONE) ? TAPER_ONE : tap_q;
    r1b_q     <= r1_prod[46:16];
    r2b_q     <= r2a_q;
    hb_q      <= ha_q;
    drv_q.r1  <= r1b_q;
    drv_q.r2  <= r2b_q;
    drv_q.h   <= hb_q;
    drv_q.k2x <= r2b_q - r1b_q;
    drv_q.k2y <= {hb_q, 1'b0};
    sqx_q     <= 62'(drv_q.k2x) * 62'(drv_q.k2x);
    sqy_q     <= 64'(drv_q.k2y) * 64'(drv_q.k2y);
    den_q     <= 65'(sqx_q) + 65'(sqy_q);
  end

  // flow control
  logic                  en, in_fire, pv;
  logic [PIPE_DEPTH-1:0] vq_q;
  logic                  ov_q, sv_q;
  res_t                  pipe_res, od_q, skd_q;

  assign en            = ~sv_q;
  assign point_i.ready = en;
  assign in_fire       = point_i.valid & en;
  assign pv            = vq_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else if (en) begin
      vq_q <= {vq_q[PIPE_DEPTH-2:0], in_fire};
    end
  end

  // front end: offset, rotate, square
  logic signed [32:0] dx1_q, dy1_q;
  logic signed [31:0] z1_q, z2_q, z3_q, z4_q;
  logic signed [50:0] pcx2_q, psy2_q, pcy2_q, psx2_q;
  logic signed [51:0] xsum3, ysum3;
  logic signed [35:0] xl3_q, yl3_q;
  logic [35:0]        xmag4, ymag4;
  logic [69:0]        xsq4_q, ysq4_q;

  assign xsum3 = 52'(pcx2_q) + 52'(psy2_q);
  assign ysum3 = 52'(pcy2_q) - 52'(psx2_q);
  assign xmag4 = xl3_q[35] ? 36'(-xl3_q) : 36'(xl3_q);
  assign ymag4 = yl3_q[35] ? 36'(-yl3_q) : 36'(yl3_q);

  // radial root
  logic [SQ1_N-1:0]   s1_rad_q  [SQ1_M];
  logic [SQ1_M+1:0]   s1_rem_q  [SQ1_M];
  logic [SQ1_M-1:0]   s1_root_q [SQ1_M+1];
  logic signed [31:0] s1_z_q    [SQ1_M+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q        <= 33'(point_i.point_x) - 33'(off_x_q);
      dy1_q        <= 33'(point_i.point_y) - 33'(off_y_q);
      z1_q         <= point_i.point_z;
      pcx2_q       <= cos_q * dx1_q;
      psy2_q       <= sin_q * dy1_q;
      pcy2_q       <= cos_q * dy1_q;
      psx2_q       <= sin_q * dx1_q;
      z2_q         <= z1_q;
      xl3_q        <= xsum3[51:16];
      yl3_q        <= ysum3[51:16];
      z3_q         <= z2_q;
      xsq4_q       <= xmag4[34:0] * xmag4[34:0];
      ysq4_q       <= ymag4[34:0] * ymag4[34:0];
      z4_q         <= z3_q;
      s1_rad_q[0]  <= xsq4_q + ysq4_q;
      s1_rem_q[0]  <= '0;
      s1_root_q[0] <= '0;
      s1_z_q[0]    <= z4_q;
    end
  end

  for (genvar j = 1; j <= SQ1_M; j++) begin : g_sq1
    logic [SQ1_M+2:0] rsh, trl, dif;
    logic             ge;
    assign rsh = {s1_rem_q[j-1][SQ1_M:0], s1_rad_q[j-1][SQ1_N-1 -: 2]};
    assign trl = {1'b0, s1_root_q[j-1], 2'b01};
    assign dif = rsh - trl;
    assign ge  = rsh >= trl;
    always_ff @(posedge clk_i) begin
      if (en) begin
        s1_root_q[j] <= {s1_root_q[j-1][SQ1_M-2:0], ge};
        s1_z_q[j]    <= s1_z_q[j-1];
      end
    end
    if (j < SQ1_M) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          s1_rem_q[j] <= ge ? dif[SQ1_M+1:0] : rsh[SQ1_M+1:0];
          s1_rad_q[j] <= {s1_rad_q[j-1][SQ1_N-3:0], 2'b00};
        end
      end
    end
  end

  // projection setup
  logic [32:0]        qr1_q, qr2_q, qr3_q, qr4_q;
  logic signed [31:0] z1b_q, z2b_q, z3b_q, z4b_q;
  logic [30:0]        cap2;
  logic [31:0]        zabs2;
  logic [32:0]        cax2_q, cax3_q, cax4_q;
  logic signed [33:0] a2_q, b2_q, cay2_q, cay3_q, cay4_q;
  logic signed [65:0] pa3_q;
  logic signed [66:0] pb3_q;
  logic signed [67:0] num4_q;

  assign cap2  = z1b_q[31] ? drv_q.r1 : drv_q.r2;
  assign zabs2 = z1b_q[31] ? 32'(-z1b_q) : 32'(z1b_q);

  // divider
  logic [64:0]        dv_rem_q  [DIV_STEPS];
  logic [31:0]        dv_quot_q [DIV_STEPS+1];
  logic               dv_zero_q [DIV_STEPS+1];
  logic               dv_full_q [DIV_STEPS+1];
  logic [32:0]        dv_qr_q   [DIV_STEPS+1];
  logic signed [31:0] dv_z_q    [DIV_STEPS+1];
  logic [32:0]        dv_cax_q  [DIV_STEPS+1];
  logic signed [33:0] dv_cay_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qr1_q        <= (s1_root_q[SQ1_M] > {2'b0, QR_LIMIT}) ? QR_LIMIT
                                                             : s1_root_q[SQ1_M][32:0];
      z1b_q        <= s1_z_q[SQ1_M];
      cax2_q       <= (qr1_q > {2'b0, cap2}) ? qr1_q - {2'b0, cap2} : '0;
      a2_q         <= $signed({3'b0, drv_q.r2}) - $signed({1'b0, qr1_q});
      b2_q         <= $signed({3'b0, drv_q.h}) - 34'(z1b_q);
      cay2_q       <= $signed({2'b0, zabs2}) - $signed({3'b0, drv_q.h});
      qr2_q        <= qr1_q;
      z2b_q        <= z1b_q;
      pa3_q        <= $signed({1'b0, drv_q.k2x}) * a2_q;
      pb3_q        <= $signed({1'b0, drv_q.k2y}) * b2_q;
      qr3_q        <= qr2_q;
      z3b_q        <= z2b_q;
      cax3_q       <= cax2_q;
      cay3_q       <= cay2_q;
      num4_q       <= 68'(pa3_q) + 68'(pb3_q);
      qr4_q        <= qr3_q;
      z4b_q        <= z3b_q;
      cax4_q       <= cax3_q;
      cay4_q       <= cay3_q;
      dv_zero_q[0] <= num4_q[67] || (num4_q == '0);
      dv_full_q[0] <= num4_q >= $signed({3'b0, den_q});
      dv_rem_q[0]  <= num4_q[64:0];
      dv_quot_q[0] <= '0;
      dv_qr_q[0]   <= qr4_q;
      dv_z_q[0]    <= z4b_q;
      dv_cax_q[0]  <= cax4_q;
      dv_cay_q[0]  <= cay4_q;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [65:0] rsh, dif;
    logic        ge;
    assign rsh = {dv_rem_q[j-1], 1'b0};
    assign dif = rsh - {1'b0, den_q};
    assign ge  = rsh >= {1'b0, den_q};
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_quot_q[j] <= {dv_quot_q[j-1][30:0], ge};
        dv_zero_q[j] <= dv_zero_q[j-1];
        dv_full_q[j] <= dv_full_q[j-1];
        dv_qr_q[j]   <= dv_qr_q[j-1];
        dv_z_q[j]    <= dv_z_q[j-1];
        dv_cax_q[j]  <= dv_cax_q[j-1];
        dv_cay_q[j]  <= dv_cay_q[j-1];
      end
    end
    if (j < DIV_STEPS) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[j] <= ge ? dif[64:0] : rsh[64:0];
        end
      end
    end
  end

  // segment distances
  logic [32:0]        t1;
  logic [63:0]        ex1;
  logic [64:0]        ey1;
  logic [31:0]        exh1_q;
  logic [32:0]        eyh1_q;
  logic [32:0]        qr5_q, cax5_q, cax6_q;
  logic signed [31:0] z5_q;
  logic signed [33:0] cay5_q, cay6_q, cbx6, cby6, cbx6_q, cby6_q;
  logic               in6_q, in7_q, in8_q;
  logic [33:0]        mbx7, mby7, may7;
  logic [65:0]        sax7_q, say7_q, sbx7_q, sby7_q;
  logic [66:0]        da8_q, db8_q;

  assign t1   = dv_zero_q[DIV_STEPS] ? '0
              : dv_full_q[DIV_STEPS] ? T_ONE : {1'b0, dv_quot_q[DIV_STEPS]};
  assign ex1  = 64'(drv_q.k2x) * 64'(t1);
  assign ey1  = 65'(drv_q.k2y) * 65'(t1);
  assign cbx6 = $signed({1'b0, qr5_q}) - $signed({3'b0, drv_q.r2})
              + $signed({2'b0, exh1_q});
  assign cby6 = 34'(z5_q) - $signed({3'b0, drv_q.h}) + $signed({1'b0, eyh1_q});
  assign mbx7 = cbx6_q[33] ? 34'(-cbx6_q) : 34'(cbx6_q);
  assign mby7 = cby6_q[33] ? 34'(-cby6_q) : 34'(cby6_q);
  assign may7 = cay6_q[33] ? 34'(-cay6_q) : 34'(cay6_q);

  // distance root
  logic [SQ2_N-1:0] s2_rad_q  [SQ2_M];
  logic [SQ2_M+1:0] s2_rem_q  [SQ2_M];
  logic [SQ2_M-1:0] s2_root_q [SQ2_M+1];
  logic             s2_in_q   [SQ2_M+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      exh1_q       <= ex1[63:32];
      eyh1_q       <= ey1[64:32];
      qr5_q        <= dv_qr_q[DIV_STEPS];
      z5_q         <= dv_z_q[DIV_STEPS];
      cax5_q       <= dv_cax_q[DIV_STEPS];
      cay5_q       <= dv_cay_q[DIV_STEPS];
      cbx6_q       <= cbx6;
      cby6_q       <= cby6;
      in6_q        <= cbx6[33] && cay5_q[33];
      cax6_q       <= cax5_q;
      cay6_q       <= cay5_q;
      sax7_q       <= cax6_q * cax6_q;
      say7_q       <= may7[32:0] * may7[32:0];
      sbx7_q       <= mbx7[32:0] * mbx7[32:0];
      sby7_q       <= mby7[32:0] * mby7[32:0];
      in7_q        <= in6_q;
      da8_q        <= 67'(sax7_q) + 67'(say7_q);
      db8_q        <= 67'(sbx7_q) + 67'(sby7_q);
      in8_q        <= in7_q;
      s2_rad_q[0]  <= {1'b0, (da8_q <= db8_q) ? da8_q : db8_q};
      s2_rem_q[0]  <= '0;
      s2_root_q[0] <= '0;
      s2_in_q[0]   <= in8_q;
    end
  end

  for (genvar j = 1; j <= SQ2_M; j++) begin : g_sq2
    logic [SQ2_M+2:0] rsh, trl, dif;
    logic             ge;
    assign rsh = {s2_rem_q[j-1][SQ2_M:0], s2_rad_q[j-1][SQ2_N-1 -: 2]};
    assign trl = {1'b0, s2_root_q[j-1], 2'b01};
    assign dif = rsh - trl;
    assign ge  = rsh >= trl;
    always_ff @(posedge clk_i) begin
      if (en) begin
        s2_root_q[j] <= {s2_root_q[j-1][SQ2_M-2:0], ge};
        s2_in_q[j]   <= s2_in_q[j-1];
      end
    end
    if (j < SQ2_M) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          s2_rem_q[j] <= ge ? dif[SQ2_M+1:0] : rsh[SQ2_M+1:0];
          s2_rad_q[j] <= {s2_rad_q[j-1][SQ2_N-3:0], 2'b00};
        end
      end
    end
  end

  // saturate and sign
  logic [30:0] dsat;
  res_t        fin_q;

  assign dsat = (s2_root_q[SQ2_M] > {3'b0, DIST_MAX}) ? DIST_MAX : s2_root_q[SQ2_M][30:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q.sd      <= s2_in_q[SQ2_M] ? -$signed({1'b0, dsat}) : $signed({1'b0, dsat});
      fin_q.in_cone <= s2_in_q[SQ2_M];
    end
  end

  assign pipe_res = fin_q;

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && result_o.ready) begin
      if (sv_q) begin
        sv_q <= 1'b0;
      end else if (!(en && pv)) begin
        ov_q <= 1'b0;
      end
    end else if (!ov_q) begin
      if (en && pv) begin
        ov_q <= 1'b1;
      end
    end else if (en && pv) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && result_o.ready) begin
      if (sv_q) begin
        od_q <= skd_q;
      end else begin
        od_q <= pipe_res;
      end
    end else if (!ov_q) begin
      od_q <= pipe_res;
    end else if (en && pv) begin
      skd_q <= pipe_res;
    end
  end

  assign result_o.valid           = ov_q;
  assign result_o.signed_distance = od_q.sd;
  assign result_o.inside_res      = od_q.in_cone;

endmodule

[rtl/ccs_checker.sv]
module ccs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [31:0] dist_i,
  input logic        inside_i
);
  import ccs_pkg::*;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(dist_i) && $stable(inside_i))
    else $error("result changed while stalled");

  a_inside_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && inside_i |-> dist_i[31] || dist_i == '0)
    else $error("inside point with positive distance");

  a_outside_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !inside_i |-> !dist_i[31] && dist_i != SD_MIN)
    else $error("outside point with negative distance");

endmodule

bind capped_cone_sdf ccs_checker u_ccs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (result_o.valid),
  .ready_i  (result_o.ready),
  .dist_i   (result_o.signed_distance),
  .inside_i (result_o.inside_res)
);

[tb/capped_cone_sdf_test.sv]
module capped_cone_sdf_test;
  import ccs_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] sd;
    logic               ins;
  } cone_res_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    logic [31:0] sd;
    logic        ins;
  } point_row_t;

  localparam int PHASES    = 9;
  localparam int PHASE_LEN = 160;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ccs_point_if pif ();
  ccs_result_if rif ();

  capped_cone_sdf u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .point_i  (pif),
    .result_o (rif)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow registers
  logic [31:0] off_x, off_y;
  logic [17:0] cos_yaw, sin_yaw;
  logic [30:0] top_rad, half_h;
  logic [16:0] taper;

  cone_res_t expected_dist_q[$];
  int errors = 0;
  int burst_mode = 0;

  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic wide_t sx32(input logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  function automatic wide_t sx18(input logic [17:0] v);
    return {{110{v[17]}}, v};
  endfunction

  function automatic cone_res_t cone_distance(input logic [31:0] px, py, pz);
    wide_t dx, dy, z, c, s, xl, yl, r2, h, tp, r1, k2x, k2y, qr, cap;
    wide_t ca_x, ca_y, az, num, den, t, cb_x, cb_y, da, db, dw;
    wide_t one32;
    logic in_cone;
    cone_res_t r;
    one32 = wide_t'(1) <<< 32;
    dx = sx32(px) - sx32(off_x);
    dy = sx32(py) - sx32(off_y);
    z  = sx32(pz);
    c  = sx18(cos_yaw);
    s  = sx18(sin_yaw);
    xl = (c * dx + s * dy) >>> 16;
    yl = (c * dy - s * dx) >>> 16;
    r2 = {97'd0, top_rad};
    h  = {97'd0, half_h};
    tp = {111'd0, taper};
    if (r2 < 7) r2 = 7;
    if (h < 7) h = 7;
    if (tp > 65536) tp = 65536;
    r1  = (r2 * tp) >>> 16;
    k2x = r2 - r1;
    k2y = 2 * h;
    qr = {64'd0, isqrt128(xl * xl + yl * yl)};
    if (qr > one32) qr = one32;
    cap  = (z < 0) ? r1 : r2;
    ca_x = qr - ((qr < cap) ? qr : cap);
    az   = (z < 0) ? -z : z;
    ca_y = az - h;
    num = k2x * (r2 - qr) + k2y * (h - z);
    den = k2x * k2x + k2y * k2y;
    if (num <= 0) t = 0;
    else if (num >= den) t = one32;
    else t = (num <<< 32) / den;
    cb_x = qr - r2 + ((k2x * t) >>> 32);
    cb_y = z - h + ((k2y * t) >>> 32);
    da = ca_x * ca_x + ca_y * ca_y;
    db = cb_x * cb_x + cb_y * cb_y;
    dw = {64'd0, isqrt128((da <= db) ? da : db)};
    if (dw > 64'h7fff_ffff) dw = 64'h7fff_ffff;
    in_cone = (cb_x < 0) && (ca_y < 0);
    r.sd  = in_cone ? 32'(-dw) : 32'(dw);
    r.ins = in_cone;
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    if (burst_mode != 0) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OFFSET_X:    off_x = val;
      REG_OFFSET_Y:    off_y = val;
      REG_COS_YAW:     cos_yaw = val[17:0];
      REG_SIN_YAW:     sin_yaw = val[17:0];
      REG_TOP_RADIUS:  top_rad = val[30:0];
      REG_HALF_HEIGHT: half_h = val[30:0];
      default:         taper = val[16:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_cone(input logic [31:0] ox, oy, cy, sy, tr, hh, tpr);
    reg_write(REG_OFFSET_X, ox);
    reg_write(REG_OFFSET_Y, oy);
    reg_write(REG_COS_YAW, cy);
    reg_write(REG_SIN_YAW, sy);
    reg_write(REG_TOP_RADIUS, tr);
    reg_write(REG_HALF_HEIGHT, hh);
    reg_write(REG_TAPER_RATIO, tpr);
    // derived constants settle
    repeat (10) @(posedge clk_i);
  endtask

  // returns the prediction for the accepted request
  task automatic send_point(input logic [31:0] px, py, pz, output cone_res_t pred);
    int g;
    bit ok;
    g = rand_gap();
    if (g > 0) begin
      pif.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    pif.valid   <= 1'b1;
    pif.point_x <= px;
    pif.point_y <= py;
    pif.point_z <= pz;
    do begin
      @(negedge clk_i);
      ok = pif.ready;
      @(posedge clk_i);
    end while (!ok);
    pred = cone_distance(px, py, pz);
    expected_dist_q.push_back(pred);
  endtask

  task automatic drain();
    pif.valid <= 1'b0;
    wait (expected_dist_q.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(input logic [31:0] base, input longint span);
    return base + 32'($urandom_range(0, 32'(2 * span)) - span);
  endfunction

  initial begin
    int stall;
    rif.ready = 1'b0;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        rif.ready <= 1'b0;
        stall--;
      end else begin
        rif.ready <= 1'b1;
        stall = rand_gap();
      end
    end
  end

  always @(negedge clk_i) begin
    cone_res_t e;
    if (rst_ni && rif.valid && rif.ready) begin
      if (expected_dist_q.size() == 0) begin
        $display("%0t: result with no request pending: sd %0d inside %0b", $time,
                 rif.signed_distance, rif.inside_res);
        errors++;
      end else begin
        e = expected_dist_q.pop_front();
        if (rif.signed_distance !== e.sd) begin
          $display("%0t: signed_distance expected %0d actual %0d", $time, e.sd,
                   rif.signed_distance);
          errors++;
        end
        if (rif.inside_res !== e.ins) begin
          $display("%0t: inside_res expected %0b actual %0b", $time, e.ins,
                   rif.inside_res);
          errors++;
        end
      end
    end
  end

  point_row_t dir_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'd0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 32'hffff_0000, 1'b0, 32'd0, 1'b0},
    '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
    '{32'h0000_c000, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'd0, 1'b0},
    '{32'h0000_ffff, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'd0, 1'b0},
    '{32'h0000_0000, 32'h0000_ffff, 32'h0000_ffff, 1'b0, 32'd0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b0, 32'd0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
    '{32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 32'h7fff_ffff, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 1'b0},
    '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'd0, 1'b0},
    '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
    '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'd0, 1'b0},
    '{32'h0000_8000, 32'h0000_8000, 32'hffff_8000, 1'b0, 32'd0, 1'b0},
    '{32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 32'd0, 1'b0}
  };

  initial begin
    cone_res_t pred;
    logic [31:0] px, py, pz;
    longint span;
    pif.valid   = 1'b0;
    pif.point_x = '0;
    pif.point_y = '0;
    pif.point_z = '0;
    off_x = '0;
    off_y = '0;
    cos_yaw = 18'd65536;
    sin_yaw = '0;
    top_rad = 31'd65536;
    half_h = 31'd65536;
    taper = 17'd49152;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (10) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, pred);
      if (dir_rows[i].known && (pred.sd !== dir_rows[i].sd || pred.ins !== dir_rows[i].ins))
      begin
        $display("%0t: row %0d prediction expected %0d/%0b actual %0d/%0b", $time, i,
                 dir_rows[i].sd, dir_rows[i].ins, pred.sd, pred.ins);
        errors++;
      end
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_cone(32'h0, 32'h0, 32'hfffe_0000, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_ffff);
        1: load_cone(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
        2: load_cone(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h0,
                     32'd7, 32'd6, 32'd65536);
        default:
          load_cone($urandom, $urandom, 32'($urandom_range(0, 131072)) - 32'd65536,
                    32'($urandom_range(0, 131072)) - 32'd65536,
                    ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h80000)),
                    ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h80000)),
                    ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 65536)));
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      span = 4 * ((top_rad > half_h) ? longint'(top_rad) : longint'(half_h)) + 16;
      if (span > 64'h4000_0000) span = 64'h4000_0000;
      for (int k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          px = near(off_x, span);
          py = near(off_y, span);
          pz = near(32'd0, span);
        end else begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end
        send_point(px, py, pz, pred);
      end
      burst_mode = 0;
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
rtl/ccs_pkg.sv
rtl/ccs_point_if.sv
rtl/ccs_result_if.sv
rtl/capped_cone_sdf.sv
rtl/ccs_checker.sv
tb/capped_cone_sdf_test.sv
